// File: rtl/pwhp_pkg.sv
// Shared types and constants for the WAVE header parser.
// Holds the result status codes and the expected RIFF/WAVE tag bytes.
// No dependencies.
package pwhp_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_TAG     = 3'd1,
        ST_FMTLEN  = 3'd2,
        ST_NOTPCM  = 3'd3,
        ST_CHAN    = 3'd4,
        ST_DATATAG = 3'd5,
        ST_TRUNC   = 3'd6
    } status_t;

    // Header offsets
    localparam logic [5:0] POS_FILE_LEN  = 6'd4;
    localparam logic [5:0] POS_WAVE      = 6'd8;
    localparam logic [5:0] POS_FMT       = 6'd12;
    localparam logic [5:0] POS_FMT_LEN   = 6'd16;
    localparam logic [5:0] POS_FMT_TYPE  = 6'd20;
    localparam logic [5:0] POS_CHAN_LO   = 6'd22;
    localparam logic [5:0] POS_CHAN_HI   = 6'd23;
    localparam logic [5:0] POS_RATE      = 6'd24;
    localparam logic [5:0] POS_BYTE_RATE = 6'd28;
    localparam logic [5:0] POS_ALIGN     = 6'd32;
    localparam logic [5:0] POS_BITS      = 6'd34;
    localparam logic [5:0] POS_CHUNK_TAG = 6'd36;
    localparam logic [5:0] POS_SIZE      = 6'd40;
    localparam logic [5:0] POS_SIZE_LAST = 6'd43;
    localparam logic [5:0] POS_FACT_SIZE = 6'd52;
    localparam logic [5:0] POS_FACT_LAST = 6'd55;

    // Expected field values
    localparam logic [7:0] FMT_LEN_PCM  = 8'd16;
    localparam logic [7:0] FMT_TYPE_PCM = 8'd1;
    localparam logic [7:0] CHAN_MONO    = 8'd1;
    localparam logic [7:0] CHAN_STEREO  = 8'd2;
    localparam logic [7:0] CHAR_D       = 8'h64;  // 'd'
    localparam logic [7:0] CHAR_F       = 8'h66;  // 'f'

    // Tag bytes, first byte at index 0
    localparam logic [7:0] TAG_RIFF [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
    localparam logic [7:0] TAG_WAVE [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
    localparam logic [7:0] TAG_FMT  [4] = '{8'h66, 8'h6d, 8'h74, 8'h20};
    localparam logic [7:0] TAG_DATA [4] = '{8'h64, 8'h61, 8'h74, 8'h61};
    localparam logic [7:0] TAG_FACT [4] = '{8'h66, 8'h61, 8'h63, 8'h74};

    localparam int OUT_DATA_W = 136;

endpackage

// File: rtl/pcm_wave_header_parser.sv
// RIFF WAVE PCM header parser, top level.
// Depends on pwhp_pkg for status codes and tag constants.
//
// Usage:
//   Input stream: one header byte per item on s_axis_tdata. s_axis_tuser
//   flags the first byte of a new file (clears all parse state), and
//   s_axis_tlast marks the last available byte of the stream.
//   Output stream: one result item per file header. m_axis_tuser holds the
//   status (0 ok, 1..5 failed check, 6 truncated); m_axis_tdata holds the
//   captured fields, all zero unless the status is ok.
//   Each byte is checked as it arrives; the result goes out on the byte that
//   completes the header, fails a check or marks stream end. Later bytes are
//   dropped until a byte with the restart flag arrives.
// Timing:
//   Input register, one stage of position compare and field capture, then
//   a result register. A result is built from the byte in the input register
//   and registered in the result register. One byte is accepted every cycle unless the stall below holds it.
// Reset and stall:
//   Reset empties both registers and returns to header offset 0. When the
//   receiver holds m_axis_tready low with a result waiting, the parse stage
//   stops and s_axis_tready falls once the input register is full.
module pcm_wave_header_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] header_byte
    input  logic                          s_axis_tuser,   // [0] restart
    input  logic                          s_axis_tlast,   // stream_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] file_length, [33:32] channels, [65:34] sample_rate,
    // [81:66] block_align, [97:82] bits_per_sample, [129:98] data_bytes,
    // [135:130] zero
    output logic [pwhp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [2:0]                    m_axis_tuser    // [2:0] status
);
    import pwhp_pkg::*;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_restart_reg;
    logic        in_end_reg;

    // Parse state
    logic [5:0]  pos_reg,   pos_next;
    logic        fact_reg,  fact_next;
    logic        fin_reg,   fin_next;
    logic [31:0] flen_reg,  flen_next;
    logic [1:0]  chan_reg,  chan_next;
    logic [31:0] rate_reg,  rate_next;
    logic [15:0] align_reg, align_next;
    logic [15:0] bits_reg,  bits_next;
    logic [31:0] size_reg,  size_next;

    // Result register
    logic        out_valid_reg;
    status_t     out_status_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic        advance;
    logic        work;
    logic [5:0]  pos_eff;
    logic        fact_eff;
    logic        fin_eff;
    status_t     err;
    logic        complete;
    logic        emit;
    status_t     status_next;
    logic [7:0]  b;
    logic [1:0]  idx;

    // Handshake: the parse stage moves when the result register is free
    assign advance       = !out_valid_reg || m_axis_tready;
    assign work          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = out_data_reg;

    // Hold the incoming item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_restart_reg <= s_axis_tuser;
            in_end_reg     <= s_axis_tlast;
        end
    end

    // Check the byte at its header offset and capture fields
    always_comb
    begin
        b        = in_byte_reg;
        pos_eff  = in_restart_reg ? 6'd0 : pos_reg;
        fact_eff = in_restart_reg ? 1'b0 : fact_reg;
        fin_eff  = in_restart_reg ? 1'b0 : fin_reg;
        idx      = pos_eff[1:0];
        err      = ST_OK;
        complete = 1'b0;

        fact_next  = fact_eff;
        flen_next  = flen_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        align_next = align_reg;
        bits_next  = bits_reg;
        size_next  = size_reg;

        if (pos_eff < POS_FILE_LEN)
        begin
            if (b != TAG_RIFF[idx]) err = ST_TAG;
        end
        else if (pos_eff < POS_WAVE)
        begin
            flen_next = {b, flen_reg[31:8]};
        end
        else if (pos_eff < POS_FMT)
        begin
            if (b != TAG_WAVE[idx]) err = ST_TAG;
        end
        else if (pos_eff < POS_FMT_LEN)
        begin
            if (b != TAG_FMT[idx]) err = ST_TAG;
        end
        else if (pos_eff < POS_FMT_TYPE)
        begin
            if (b != ((pos_eff == POS_FMT_LEN) ? FMT_LEN_PCM : 8'd0)) err = ST_FMTLEN;
        end
        else if (pos_eff < POS_CHAN_LO)
        begin
            if (b != ((pos_eff == POS_FMT_TYPE) ? FMT_TYPE_PCM : 8'd0)) err = ST_NOTPCM;
        end
        else if (pos_eff == POS_CHAN_LO)
        begin
            if (b != CHAN_MONO && b != CHAN_STEREO) err = ST_CHAN;
            else chan_next = b[1:0];
        end
        else if (pos_eff == POS_CHAN_HI)
        begin
            if (b != 8'd0) err = ST_CHAN;
        end
        else if (pos_eff < POS_BYTE_RATE)
        begin
            rate_next = {b, rate_reg[31:8]};
        end
        else if (pos_eff < POS_ALIGN)
        begin
            // byte rate: skip
        end
        else if (pos_eff < POS_BITS)
        begin
            align_next = {b, align_reg[15:8]};
        end
        else if (pos_eff < POS_CHUNK_TAG)
        begin
            bits_next = {b, bits_reg[15:8]};
        end
        else if (pos_eff == POS_CHUNK_TAG)
        begin
            if (b == CHAR_D) fact_next = 1'b0;
            else if (b == CHAR_F) fact_next = 1'b1;
            else err = ST_DATATAG;
        end
        else if (pos_eff < POS_SIZE)
        begin
            if (b != (fact_eff ? TAG_FACT[idx] : TAG_DATA[idx])) err = ST_DATATAG;
        end
        else if (!fact_eff)
        begin
            size_next = {b, size_reg[31:8]};
            complete  = (pos_eff >= POS_SIZE_LAST);
        end
        else if (pos_eff < POS_FACT_SIZE)
        begin
            // fact chunk body: skip unchecked
        end
        else
        begin
            size_next = {b, size_reg[31:8]};
            complete  = (pos_eff >= POS_FACT_LAST);
        end

        // Pick the result status, error first
        if (err != ST_OK)      status_next = err;
        else if (complete)     status_next = ST_OK;
        else                   status_next = ST_TRUNC;

        emit     = !fin_eff && (err != ST_OK || complete || in_end_reg);
        fin_next = fin_eff || emit;
        pos_next = (fin_eff || emit) ? pos_eff : pos_eff + 6'd1;
    end

    // Advance control state of the parser
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 6'd0;
            fact_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else if (work)
        begin
            pos_reg  <= pos_next;
            fin_reg  <= fin_next;
            if (!fin_eff)
            begin
                fact_reg <= fact_next;
            end
        end
    end

    // Capture header fields
    always_ff @(posedge clk)
    begin
        if (work && !fin_eff)
        begin
            flen_reg  <= flen_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            align_reg <= align_next;
            bits_reg  <= bits_next;
            size_reg  <= size_next;
        end
    end

    // Result register: load on a result, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (work && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (work && emit)
        begin
            out_status_reg <= status_next;
            if (status_next == ST_OK)
            begin
                out_data_reg <= {6'd0, size_next, bits_next, align_next,
                                 rate_next, chan_next, flen_next};
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for pcm_wave_header_parser: feeds WAVE header byte streams and checks every result.
// A behavioral parser predicts each result. A scoreboard class compares it field by field.
// Depends on pwhp_pkg and rtl/pcm_wave_header_parser.sv.
module tb;
    import pwhp_pkg::*;

    localparam int BYTE_TARGET    = 1100;
    localparam int HOLD_OFF_AT    = 300;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    // One parsed header as it leaves the block
    typedef struct packed {
        status_t     status;
        logic [31:0] file_length;
        logic [1:0]  channels;
        logic [31:0] sample_rate;
        logic [15:0] block_align;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
    } wave_info_t;

    // Header parser model and store of headers still to come out
    class wave_header_checker;
        logic [5:0]  byte_pos;
        bit          fact_seen;
        bit          hdr_done;
        logic [31:0] flen_acc;
        logic [1:0]  chan_acc;
        logic [31:0] rate_acc;
        logic [15:0] align_acc;
        logic [15:0] bits_acc;
        logic [31:0] size_acc;
        wave_info_t  expected_headers[$];
        int          mismatch_count;

        function new();
            clear_parse();
            mismatch_count    = 0;
        endfunction

        function void clear_parse();
            byte_pos  = '0;
            fact_seen = 1'b0;
            hdr_done  = 1'b0;
            flen_acc  = '0;
            chan_acc  = '0;
            rate_acc  = '0;
            align_acc = '0;
            bits_acc  = '0;
            size_acc  = '0;
        endfunction

        // Queue a result; captured fields only travel with an ok status
        function void post_result(status_t st);
            wave_info_t r;
            r        = '0;
            r.status = st;
            if (st == ST_OK)
            begin
                r.file_length     = flen_acc;
                r.channels        = chan_acc;
                r.sample_rate     = rate_acc;
                r.block_align     = align_acc;
                r.bits_per_sample = bits_acc;
                r.data_bytes      = size_acc;
            end
            expected_headers.push_back(r);
            hdr_done = 1'b1;
        endfunction

        // Advance the parse by one accepted byte
        function void parse_byte(logic [7:0] b, logic restart, logic last);
            status_t    err;
            bit         complete;
            logic [5:0] p;
            if (restart)
                clear_parse();
            if (hdr_done)
                return;
            err      = ST_OK;
            complete = 1'b0;
            p        = byte_pos;
            // all tags start on multiples of four, so p[1:0] indexes the tag
            if (p < POS_FILE_LEN)
            begin
                if (b != TAG_RIFF[p[1:0]]) err = ST_TAG;
            end
            else if (p < POS_WAVE)
                flen_acc = {b, flen_acc[31:8]};
            else if (p < POS_FMT)
            begin
                if (b != TAG_WAVE[p[1:0]]) err = ST_TAG;
            end
            else if (p < POS_FMT_LEN)
            begin
                if (b != TAG_FMT[p[1:0]]) err = ST_TAG;
            end
            else if (p < POS_FMT_TYPE)
            begin
                if (b != ((p == POS_FMT_LEN) ? FMT_LEN_PCM : 8'd0)) err = ST_FMTLEN;
            end
            else if (p < POS_CHAN_LO)
            begin
                if (b != ((p == POS_FMT_TYPE) ? FMT_TYPE_PCM : 8'd0)) err = ST_NOTPCM;
            end
            else if (p == POS_CHAN_LO)
            begin
                if (b != CHAN_MONO && b != CHAN_STEREO)
                    err = ST_CHAN;
                else
                    chan_acc = b[1:0];
            end
            else if (p == POS_CHAN_HI)
            begin
                if (b != 8'd0) err = ST_CHAN;
            end
            else if (p < POS_BYTE_RATE)
                rate_acc = {b, rate_acc[31:8]};
            else if (p < POS_ALIGN)
            begin
                // byte rate is read past
            end
            else if (p < POS_BITS)
                align_acc = {b, align_acc[15:8]};
            else if (p < POS_CHUNK_TAG)
                bits_acc = {b, bits_acc[15:8]};
            else if (p == POS_CHUNK_TAG)
            begin
                if (b == CHAR_D)
                    fact_seen = 1'b0;
                else if (b == CHAR_F)
                    fact_seen = 1'b1;
                else
                    err = ST_DATATAG;
            end
            else if (p < POS_SIZE)
            begin
                if (b != (fact_seen ? TAG_FACT[p[1:0]] : TAG_DATA[p[1:0]])) err = ST_DATATAG;
            end
            else if (!fact_seen)
            begin
                size_acc = {b, size_acc[31:8]};
                complete = (p >= POS_SIZE_LAST);
            end
            else if (p < POS_FACT_SIZE)
            begin
                // fact chunk body is skipped unchecked
            end
            else
            begin
                size_acc = {b, size_acc[31:8]};
                complete = (p >= POS_FACT_LAST);
            end

            // a failed check wins over completion and truncation
            if (err != ST_OK)
                post_result(err);
            else if (complete)
                post_result(ST_OK);
            else if (last)
                post_result(ST_TRUNC);
            else
                byte_pos = p + 6'd1;
        endfunction

        // Compare one result item with the oldest queued header
        function void check_header_result(logic [2:0] st, logic [OUT_DATA_W-1:0] d);
            wave_info_t want;
            bit         bad;
            if (expected_headers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("ERROR: result with nothing expected: status %0d data %h", st, d);
                return;
            end
            want = expected_headers.pop_front();
            bad  = (st != want.status) || (d[31:0] != want.file_length)
                || (d[33:32] != want.channels) || (d[65:34] != want.sample_rate)
                || (d[81:66] != want.block_align) || (d[97:82] != want.bits_per_sample)
                || (d[129:98] != want.data_bytes) || (d[OUT_DATA_W-1:130] != '0);
            if (bad)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                begin
                    $display("ERROR: status %0d/%0d len %h/%h ch %0d/%0d rate %h/%h",
                             want.status, st, want.file_length, d[31:0],
                             want.channels, d[33:32], want.sample_rate, d[65:34]);
                    $display("       align %h/%h bits %h/%h size %h/%h pad %h (expected/actual)",
                             want.block_align, d[81:66], want.bits_per_sample, d[97:82],
                             want.data_bytes, d[129:98], d[OUT_DATA_W-1:130]);
                end
            end
        endfunction

        function int pending();
            return expected_headers.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0]            m_axis_tuser;

    wave_header_checker sb = new();
    int bytes_accepted = 0;
    int idle_cycles    = 0;
    int burst_left     = 0;

    pcm_wave_header_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watch both handshakes, feed the checker and guard against a hang
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            sb.parse_byte(s_axis_tdata, s_axis_tuser, s_axis_tlast);
            bytes_accepted++;
        end
        if (m_axis_tvalid && m_axis_tready)
            sb.check_header_result(m_axis_tuser, m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", idle_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: switch between stall patterns, with one long hold-off
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        mode          = 0;
        mode_left     = 0;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready = 1'b0;
            end
            else if (!hold_done && bytes_accepted >= HOLD_OFF_AT)
            begin
                hold_done     = 1'b1;
                hold_left     = HOLD_OFF_LEN;
                m_axis_tready = 1'b0;
            end
            else
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = 1'($urandom_range(0, 1));
                    default: m_axis_tready = ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    function automatic logic [7:0] fill_byte(fill_t fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build a well-formed header with the given chunk kind, channel byte and field fill
    function automatic void build_header(ref logic [7:0] q[$], input bit with_fact,
                                         input logic [7:0] ch, input fill_t fill);
        q.delete();
        for (int i = 0; i < 4; i++) q.push_back(TAG_RIFF[i]);
        repeat (4) q.push_back(fill_byte(fill));
        for (int i = 0; i < 4; i++) q.push_back(TAG_WAVE[i]);
        for (int i = 0; i < 4; i++) q.push_back(TAG_FMT[i]);
        q.push_back(FMT_LEN_PCM);
        repeat (3) q.push_back(8'h00);
        q.push_back(FMT_TYPE_PCM);
        q.push_back(8'h00);
        q.push_back(ch);
        q.push_back(8'h00);
        // rate, byte rate, align, bits
        repeat (12) q.push_back(fill_byte(fill));
        if (with_fact)
        begin
            for (int i = 0; i < 4; i++) q.push_back(TAG_FACT[i]);
            repeat (12) q.push_back(fill_byte(fill));
        end
        else
            for (int i = 0; i < 4; i++) q.push_back(TAG_DATA[i]);
        repeat (4) q.push_back(fill_byte(fill));
    endfunction

    // Offer one byte at the falling edge and hold it until accepted
    task automatic push_byte(input logic [7:0] b, input logic rs, input logic se);
        if (burst_left == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 12);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tuser  = rs;
        s_axis_tlast  = se;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        @(negedge clk);
    endtask

    // Send the first count bytes; restart flag on the first as asked, stream end as asked
    task automatic send_seq(ref logic [7:0] q[$], input bit first_rs, input int count,
                            input bit last_end, input bit stray);
        bit se;
        for (int i = 0; i < count; i++)
        begin
            if (i == count - 1)
                se = last_end;
            else
                se = stray && ($urandom_range(0, 49) == 0);
            push_byte(q[i], (i == 0) ? first_rs : 1'b0, se);
        end
    endtask

    task automatic run_directed();
        logic [7:0] q[$];
        int         cut;
        bit         rs;
        bit         se;
        for (int t = 0; t < 19; t++)
        begin
            build_header(q, (t == 1 || t == 13 || t == 17),
                         (t == 1 || t == 2) ? CHAN_STEREO : CHAN_MONO,
                         (t == 0) ? FILL_ZERO : ((t == 1) ? FILL_ONES : FILL_RANDOM));
            cut = q.size();
            rs  = (t != 0);  // first header relies on reset alone
            se  = (t == 1 || t == 17);
            case (t)
                2:  begin q[0] = 8'h00; cut = 1; se = 1'b1; end  // bad tag beats stream end
                3:  q[10] = 8'h00;
                4:  q[15] = 8'h00;
                5:  q[16] = 8'd18;
                6:  q[19] = 8'd1;
                7:  q[20] = 8'd3;
                8:  q[21] = 8'd1;
                9:  q[22] = 8'd0;
                10: q[22] = 8'd3;
                11: q[23] = 8'd1;
                12: q[36] = 8'h4c;
                13: q[38] = 8'h00;
                14: q[39] = 8'h00;
                15: begin cut = 21; se = 1'b1; end
                16: cut = 30;                               // dropped mid-header, next restarts
                18: begin cut = 1; se = 1'b1; end           // restart and stream end on one byte
                default: ;
            endcase
            send_seq(q, rs, cut, se, 1'b0);
            // bytes after a finished header, stream end among them
            if (t == 1)
            begin
                push_byte(TAG_RIFF[0], 1'b0, 1'b1);
                push_byte(8'hff, 1'b0, 1'b0);
            end
        end
    endtask

    task automatic run_random();
        logic [7:0] q[$];
        int         kind;
        int         pos;
        fill_t      fill;
        while (bytes_accepted < BYTE_TARGET)
        begin
            kind = $urandom_range(0, 99);
            case ($urandom_range(0, 5))
                4:       fill = FILL_ZERO;
                5:       fill = FILL_ONES;
                default: fill = FILL_RANDOM;
            endcase
            build_header(q, 1'($urandom_range(0, 1)), 8'($urandom_range(1, 2)), fill);
            if (kind < 45)
            begin
                // clean header, then a few ignored bytes
                send_seq(q, $urandom_range(0, 9) != 0, q.size(), $urandom_range(0, 2) == 0, 1'b1);
                repeat ($urandom_range(0, 3))
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
            else if (kind < 65)
            begin
                // one corrupted byte anywhere
                pos    = $urandom_range(0, q.size() - 1);
                q[pos] = q[pos] ^ 8'($urandom_range(1, 255));
                send_seq(q, $urandom_range(0, 9) != 0, q.size(), 1'($urandom_range(0, 1)), 1'b0);
            end
            else if (kind < 80)
                send_seq(q, 1'b1, $urandom_range(1, q.size() - 1), 1'b1, 1'b0);
            else if (kind < 90)
                send_seq(q, 1'b1, $urandom_range(1, q.size() - 1), 1'b0, 1'b0);
            else
                repeat ($urandom_range(1, 8))
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
        end
    endtask

    // Reset, stimulus, drain, verdict
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        s_axis_tlast  = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();
        s_axis_tvalid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
